// File: rtl/pwc_pkg.sv
// shared types and constants for the polygon winding containment unit
package pwc_pkg;

   localparam int COORD_BITS_DEF   = 24;
   localparam int WINDING_BITS_DEF = 16;
   localparam int Y_TOL_BITS       = 16;
   localparam int CROSS_TOL_BITS   = 40;
   localparam int CSR_DATA_BITS    = 40;
   localparam int CSR_INDEX_BITS   = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_Y_TOL     = 1'b0,
      CSR_CROSS_TOL = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_QUERY  = 1'b0,
      KIND_VERTEX = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic valid;
      logic is_query;
      logic ring_end;
      logic last;
   } ctl_type;

endpackage

// File: rtl/pwc_if.sv
// valid/ready channel interfaces for query/vertex words and result words
interface pwc_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic                         item_kind;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic                         ring_last;
   logic                         query_last;

   modport source (output valid, item_kind, coord_x, coord_y, ring_last, query_last,
                   input ready);
   modport sink   (input valid, item_kind, coord_x, coord_y, ring_last, query_last,
                   output ready);
endinterface

interface pwc_rsp_if #(parameter int WINDING_BITS = 16);
   logic                           valid;
   logic                           ready;
   logic                           inside_res;
   logic signed [WINDING_BITS-1:0] winding_total;

   modport source (output valid, inside_res, winding_total, input ready);
   modport sink   (input valid, inside_res, winding_total, output ready);
endinterface

// File: rtl/polygon_winding_containment_unit.sv
// top level of the streaming point-in-polygon winding number unit
//
//   channel   direction  handshake      word
//   req_chan  in         valid/ready    item_kind, coord_x, coord_y, ring_last, query_last
//   rsp_chan  out        valid/ready    inside_res, winding_total
//   csr_*     in         write enable   csr_index, csr_wdata
//
// one word accepted per cycle while req_chan is not stalled; a result follows its last vertex through the pipeline
// pipeline: operand differences, products, side compare, winding update and result
// reset clears ring tracking, winding sum, tolerances and all valid bits
// req_chan stalls only while a finished result is held and the next result is waiting
module polygon_winding_containment_unit
   import pwc_pkg::*;
#(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int WINDING_BITS = WINDING_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   pwc_req_if.sink                   req_chan,
   pwc_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [Y_TOL_BITS-1:0]     y_tol_ff;
   logic [CROSS_TOL_BITS-1:0] cross_tol_ff;
   logic                      en, stall, accept;
   ctl_type                   ctl_s1, ctl_s2_ff, ctl_s3_ff;
   logic signed [COORD_BITS:0] a_dx, a_dpy, a_dy, a_dpx, b_dx, b_dpy, b_dy, b_dpx;
   logic                      a_up, a_dn, b_up, b_dn;
   logic                      a_inc, a_dec, b_inc, b_dec;

   assign en             = !stall;
   assign req_chan.ready = en;
   assign accept         = req_chan.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_tol_ff     <= '0;
         cross_tol_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_Y_TOL: begin
               y_tol_ff <= csr_wdata[Y_TOL_BITS-1:0];
            end
            CSR_CROSS_TOL: begin
               cross_tol_ff <= csr_wdata[CROSS_TOL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s2_ff <= '0;
         ctl_s3_ff <= '0;
      end else if (en) begin
         ctl_s2_ff <= ctl_s1;
         ctl_s3_ff <= ctl_s2_ff;
      end
   end

   pwc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .accept     (accept),
      .item_kind  (req_chan.item_kind),
      .coord_x    (req_chan.coord_x),
      .coord_y    (req_chan.coord_y),
      .ring_last  (req_chan.ring_last),
      .query_last (req_chan.query_last),
      .y_tol      (y_tol_ff),
      .ctl        (ctl_s1),
      .a_dx       (a_dx),
      .a_dpy      (a_dpy),
      .a_dy       (a_dy),
      .a_dpx      (a_dpx),
      .a_up       (a_up),
      .a_dn       (a_dn),
      .b_dx       (b_dx),
      .b_dpy      (b_dpy),
      .b_dy       (b_dy),
      .b_dpx      (b_dpx),
      .b_up       (b_up),
      .b_dn       (b_dn)
   );

   pwc_edge #(.COORD_BITS(COORD_BITS)) u_edge_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .dx        (a_dx),
      .dpy       (a_dpy),
      .dy        (a_dy),
      .dpx       (a_dpx),
      .up        (a_up),
      .dn        (a_dn),
      .cross_tol (cross_tol_ff),
      .inc       (a_inc),
      .dec       (a_dec)
   );

   pwc_edge #(.COORD_BITS(COORD_BITS)) u_edge_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .dx        (b_dx),
      .dpy       (b_dpy),
      .dy        (b_dy),
      .dpx       (b_dpx),
      .up        (b_up),
      .dn        (b_dn),
      .cross_tol (cross_tol_ff),
      .inc       (b_inc),
      .dec       (b_dec)
   );

   pwc_accum #(.WINDING_BITS(WINDING_BITS)) u_accum (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .ctl           (ctl_s3_ff),
      .a_inc         (a_inc),
      .a_dec         (a_dec),
      .b_inc         (b_inc),
      .b_dec         (b_dec),
      .rsp_ready     (rsp_chan.ready),
      .stall         (stall),
      .rsp_valid     (rsp_chan.valid),
      .inside_res    (rsp_chan.inside_res),
      .winding_total (rsp_chan.winding_total)
   );

endmodule

// File: rtl/pwc_front.sv
// ring tracking state, edge operand differences and y classification
module pwc_front
   import pwc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          accept,
   input  logic                          item_kind,
   input  logic signed [COORD_BITS-1:0]  coord_x,
   input  logic signed [COORD_BITS-1:0]  coord_y,
   input  logic                          ring_last,
   input  logic                          query_last,
   input  logic [Y_TOL_BITS-1:0]         y_tol,
   output ctl_type                       ctl,
   output logic signed [COORD_BITS:0]    a_dx,
   output logic signed [COORD_BITS:0]    a_dpy,
   output logic signed [COORD_BITS:0]    a_dy,
   output logic signed [COORD_BITS:0]    a_dpx,
   output logic                          a_up,
   output logic                          a_dn,
   output logic signed [COORD_BITS:0]    b_dx,
   output logic signed [COORD_BITS:0]    b_dpy,
   output logic signed [COORD_BITS:0]    b_dy,
   output logic signed [COORD_BITS:0]    b_dpx,
   output logic                          b_up,
   output logic                          b_dn
);

   localparam int DW = COORD_BITS + 1;
   localparam int YW = ((DW > Y_TOL_BITS + 1) ? DW : Y_TOL_BITS + 1) + 1;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, fx_ff, fy_ff, px_ff, py_ff;
   logic                         started_ff;
   logic signed [COORD_BITS-1:0] fx_eff, fy_eff;
   logic signed [YW-1:0]         ytol_ext;
   logic                         above_prev, above_cur, above_first;
   logic                         is_vertex, ring_end;
   ctl_type                      ctl_ff, ctl_in;
   logic signed [DW-1:0]         a_dx_ff, a_dpy_ff, a_dy_ff, a_dpx_ff;
   logic signed [DW-1:0]         b_dx_ff, b_dpy_ff, b_dy_ff, b_dpx_ff;
   logic                         a_up_ff, a_dn_ff, b_up_ff, b_dn_ff;
   logic                         a_up_in, a_dn_in, b_up_in, b_dn_in;

   assign is_vertex = (item_kind_type'(item_kind) == KIND_VERTEX);
   assign ring_end  = ring_last | query_last;
   assign fx_eff    = started_ff ? fx_ff : coord_x;
   assign fy_eff    = started_ff ? fy_ff : coord_y;
   assign ytol_ext  = $signed(YW'({1'b0, y_tol}));

   assign above_prev  = (YW'(py_ff)  - YW'(qy_ff)) > ytol_ext;
   assign above_cur   = (YW'(coord_y) - YW'(qy_ff)) > ytol_ext;
   assign above_first = (YW'(fy_eff) - YW'(qy_ff)) > ytol_ext;

   always_comb begin
      ctl_in.valid    = accept;
      ctl_in.is_query = !is_vertex;
      ctl_in.ring_end = ring_end;
      ctl_in.last     = query_last;
      // edge from the previous vertex to this one
      a_up_in = accept && is_vertex && started_ff && !above_prev && above_cur;
      a_dn_in = accept && is_vertex && started_ff && above_prev && !above_cur;
      // ring-closing edge from this vertex back to the first one
      b_up_in = accept && is_vertex && ring_end && !above_cur && above_first;
      b_dn_in = accept && is_vertex && ring_end && above_cur && !above_first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff      <= '0;
         qy_ff      <= '0;
         fx_ff      <= '0;
         fy_ff      <= '0;
         px_ff      <= '0;
         py_ff      <= '0;
         started_ff <= 1'b0;
      end else if (accept) begin
         if (!is_vertex) begin
            qx_ff      <= coord_x;
            qy_ff      <= coord_y;
            started_ff <= 1'b0;
         end else begin
            if (!started_ff) begin
               fx_ff <= coord_x;
               fy_ff <= coord_y;
            end
            px_ff      <= coord_x;
            py_ff      <= coord_y;
            started_ff <= !ring_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         a_up_ff <= 1'b0;
         a_dn_ff <= 1'b0;
         b_up_ff <= 1'b0;
         b_dn_ff <= 1'b0;
      end else if (en) begin
         ctl_ff  <= ctl_in;
         a_up_ff <= a_up_in;
         a_dn_ff <= a_dn_in;
         b_up_ff <= b_up_in;
         b_dn_ff <= b_dn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dx_ff  <= DW'(coord_x) - DW'(px_ff);
         a_dpy_ff <= DW'(qy_ff)   - DW'(py_ff);
         a_dy_ff  <= DW'(coord_y) - DW'(py_ff);
         a_dpx_ff <= DW'(qx_ff)   - DW'(px_ff);
         b_dx_ff  <= DW'(fx_eff)  - DW'(coord_x);
         b_dpy_ff <= DW'(qy_ff)   - DW'(coord_y);
         b_dy_ff  <= DW'(fy_eff)  - DW'(coord_y);
         b_dpx_ff <= DW'(qx_ff)   - DW'(coord_x);
      end
   end

   assign ctl   = ctl_ff;
   assign a_dx  = a_dx_ff;
   assign a_dpy = a_dpy_ff;
   assign a_dy  = a_dy_ff;
   assign a_dpx = a_dpx_ff;
   assign a_up  = a_up_ff;
   assign a_dn  = a_dn_ff;
   assign b_dx  = b_dx_ff;
   assign b_dpy = b_dpy_ff;
   assign b_dy  = b_dy_ff;
   assign b_dpx = b_dpx_ff;
   assign b_up  = b_up_ff;
   assign b_dn  = b_dn_ff;

endmodule

// File: rtl/pwc_edge.sv
// cross product side test of one edge, products then tolerance compare
module pwc_edge
   import pwc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic signed [COORD_BITS:0]    dx,
   input  logic signed [COORD_BITS:0]    dpy,
   input  logic signed [COORD_BITS:0]    dy,
   input  logic signed [COORD_BITS:0]    dpx,
   input  logic                          up,
   input  logic                          dn,
   input  logic [CROSS_TOL_BITS-1:0]     cross_tol,
   output logic                          inc,
   output logic                          dec
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int CW = ((PW + 1 > CROSS_TOL_BITS + 1) ? PW + 1 : CROSS_TOL_BITS + 1) + 1;

   logic signed [PW-1:0] prod_a_ff, prod_b_ff;
   logic                 up_ff, dn_ff, inc_ff, dec_ff;
   logic signed [CW-1:0] cross_sum, tol_pos, tol_neg;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff <= PW'(dx) * PW'(dpy);
         prod_b_ff <= PW'(dy) * PW'(dpx);
      end
   end

   assign cross_sum = CW'(prod_a_ff) - CW'(prod_b_ff);
   assign tol_pos   = $signed(CW'({1'b0, cross_tol}));
   assign tol_neg   = -tol_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff  <= 1'b0;
         dn_ff  <= 1'b0;
         inc_ff <= 1'b0;
         dec_ff <= 1'b0;
      end else if (en) begin
         up_ff  <= up;
         dn_ff  <= dn;
         inc_ff <= up_ff && (cross_sum > tol_pos);
         dec_ff <= dn_ff && (cross_sum < tol_neg);
      end
   end

   assign inc = inc_ff;
   assign dec = dec_ff;

endmodule

// File: rtl/pwc_accum.sv
// saturating winding sum, sticky reject flag and result word register
module pwc_accum
   import pwc_pkg::*;
#(
   parameter int WINDING_BITS = WINDING_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  ctl_type                        ctl,
   input  logic                           a_inc,
   input  logic                           a_dec,
   input  logic                           b_inc,
   input  logic                           b_dec,
   input  logic                           rsp_ready,
   output logic                           stall,
   output logic                           rsp_valid,
   output logic                           inside_res,
   output logic signed [WINDING_BITS-1:0] winding_total
);

   localparam logic signed [WINDING_BITS-1:0] WMAX = {1'b0, {(WINDING_BITS-1){1'b1}}};
   localparam logic signed [WINDING_BITS-1:0] WMIN = {1'b1, {(WINDING_BITS-1){1'b0}}};
   localparam logic signed [WINDING_BITS-1:0] WONE = WINDING_BITS'(1);

   logic signed [WINDING_BITS-1:0] acc_ff, acc_in, step_a, step_b;
   logic                           rej_ff, rej_in, rej_end;
   logic                           out_valid_ff, out_valid_in;
   logic                           inside_ff, inside_in;
   logic signed [WINDING_BITS-1:0] total_ff;
   logic                           emit;

   assign emit  = ctl.valid && !ctl.is_query && ctl.last;
   assign stall = emit && out_valid_ff && !rsp_ready;

   always_comb begin
      step_a = acc_ff;
      if (a_inc && acc_ff != WMAX) begin
         step_a = acc_ff + WONE;
      end else if (a_dec && acc_ff != WMIN) begin
         step_a = acc_ff - WONE;
      end
      step_b = step_a;
      if (b_inc && step_a != WMAX) begin
         step_b = step_a + WONE;
      end else if (b_dec && step_a != WMIN) begin
         step_b = step_a - WONE;
      end
      rej_end   = rej_ff || (ctl.ring_end && step_b == '0);
      inside_in = !rej_end;
      acc_in    = acc_ff;
      rej_in    = rej_ff;
      if (ctl.valid) begin
         if (ctl.is_query || ctl.last) begin
            acc_in = '0;
            rej_in = 1'b0;
         end else begin
            acc_in = step_b;
            rej_in = rej_end;
         end
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      if (en && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rej_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (en) begin
            acc_ff <= acc_in;
            rej_ff <= rej_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && emit) begin
         inside_ff <= inside_in;
         total_ff  <= step_b;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign inside_res    = inside_ff;
   assign winding_total = total_ff;

endmodule

// File: rtl/pwc_checker.sv
// port level checks on the result channel, bound to the top level
module pwc_checker
   import pwc_pkg::*;
#(
   parameter int WINDING_BITS = WINDING_BITS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           inside_res,
   input logic signed [WINDING_BITS-1:0] winding_total
);

   // a held result word must stay up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a held result word must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(inside_res) && $stable(winding_total))
      else $error("result word changed while stalled");

   // an inside verdict needs a nonzero final winding total
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && inside_res |-> winding_total != '0)
      else $error("inside reported with zero winding total");

   // no result comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

bind polygon_winding_containment_unit pwc_checker #(.WINDING_BITS(WINDING_BITS)) u_pwc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .inside_res    (rsp_chan.inside_res),
   .winding_total (rsp_chan.winding_total)
);
